// File: hdl/hzgb_pkg.sv
// Shared types and constants for the HZ to GB byte decoder.
package hzgb_pkg;

	localparam int BYTE_W    = 8;
	localparam int CHANNEL_W = 3;
	localparam int STATE_W   = 4;

	// Per-channel decoder states
	typedef enum logic [STATE_W-1:0] {
		ST_ASC = 4'd0,  // plain ascii
		ST_PHZ = 4'd1,  // saw '~'
		ST_HZ  = 4'd2,  // hz span, first half
		ST_HZ2 = 4'd3,  // hz span, second half
		ST_HZA = 4'd4,  // hz span, after space
		ST_HZT = 4'd5,  // hz span, saw '~'
		ST_PZW = 4'd6,  // saw 'z' at line start
		ST_ZW  = 4'd7,  // zW line, first half
		ST_ZW2 = 4'd8,  // zW line, second half
		ST_ZWA = 4'd9   // zW line, after space
	} decode_state_t;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_TILDE  = 8'h7e;
	localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7b;
	localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7d;
	localparam logic [BYTE_W-1:0] CH_Z      = 8'h7a;
	localparam logic [BYTE_W-1:0] CH_W      = 8'h57;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
	localparam logic [BYTE_W-1:0] GB_MARK   = 8'h80;
	localparam logic [6:0]        GB_LOW    = 7'h21;
	localparam logic [6:0]        GB_HIGH   = 7'h7e;

	// State kept for one channel
	typedef struct packed {
		decode_state_t state;
		logic          line_start;
	} chan_state_t;

	// Result of decoding one byte
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		chan_state_t       next;
	} decode_res_t;

endpackage

// File: hdl/hzgb_decode.sv
// Combinational next-state and output function for one byte of one channel.
module hzgb_decode (
	input  logic [hzgb_pkg::BYTE_W-1:0] in_byte,
	input  hzgb_pkg::chan_state_t       cur,
	output hzgb_pkg::decode_res_t       res
);

	logic                         gb_half;
	logic [hzgb_pkg::BYTE_W-1:0]  out_b;
	hzgb_pkg::decode_state_t      nxt;
	logic                         is_sp;
	logic                         is_bs;
	logic                         is_eol;

	// low 7 bits in the printable GB range, bit 7 ignored
	assign gb_half = (in_byte[6:0] >= hzgb_pkg::GB_LOW) && (in_byte[6:0] <= hzgb_pkg::GB_HIGH);
	assign is_sp   = (in_byte == hzgb_pkg::CH_SPACE);
	assign is_bs   = (in_byte == hzgb_pkg::CH_BS);
	assign is_eol  = (in_byte == hzgb_pkg::CH_LF) || (in_byte == hzgb_pkg::CH_CR);

	// state transitions and bit 7 marking
	always_comb begin
		out_b = in_byte;
		nxt   = hzgb_pkg::ST_ASC;
		case (cur.state)
			hzgb_pkg::ST_ASC: begin
				if (in_byte == hzgb_pkg::CH_TILDE)
					nxt = hzgb_pkg::ST_PHZ;
				else if (in_byte == hzgb_pkg::CH_Z && cur.line_start)
					nxt = hzgb_pkg::ST_PZW;
			end
			hzgb_pkg::ST_PHZ: begin
				nxt = (in_byte == hzgb_pkg::CH_LBRACE) ? hzgb_pkg::ST_HZ : hzgb_pkg::ST_ASC;
			end
			hzgb_pkg::ST_HZ: begin
				if (in_byte == hzgb_pkg::CH_TILDE) begin
					nxt = hzgb_pkg::ST_HZT;
				end else if (is_sp) begin
					nxt = hzgb_pkg::ST_HZA;
				end else if (is_bs) begin
					nxt = hzgb_pkg::ST_HZ2;
				end else if (gb_half) begin
					out_b = in_byte | hzgb_pkg::GB_MARK;
					nxt   = hzgb_pkg::ST_HZ2;
				end
			end
			hzgb_pkg::ST_HZA: begin
				nxt = hzgb_pkg::ST_HZ;
			end
			hzgb_pkg::ST_HZ2: begin
				if (is_sp || is_bs) begin
					nxt = hzgb_pkg::ST_HZ;
				end else if (gb_half) begin
					out_b = in_byte | hzgb_pkg::GB_MARK;
					nxt   = hzgb_pkg::ST_HZ;
				end
			end
			hzgb_pkg::ST_HZT: begin
				nxt = (in_byte == hzgb_pkg::CH_RBRACE) ? hzgb_pkg::ST_ASC : hzgb_pkg::ST_HZ;
			end
			hzgb_pkg::ST_PZW: begin
				nxt = (in_byte == hzgb_pkg::CH_W) ? hzgb_pkg::ST_ZW : hzgb_pkg::ST_ASC;
			end
			hzgb_pkg::ST_ZW: begin
				// backspace is not special in the first half of a zW line and falls to ascii
				if (is_sp) begin
					nxt = hzgb_pkg::ST_ZWA;
				end else if (is_eol) begin
					nxt = hzgb_pkg::ST_ASC;
				end else if (gb_half) begin
					out_b = in_byte | hzgb_pkg::GB_MARK;
					nxt   = hzgb_pkg::ST_ZW2;
				end
			end
			hzgb_pkg::ST_ZWA: begin
				nxt = hzgb_pkg::ST_ZW;
			end
			hzgb_pkg::ST_ZW2: begin
				if (is_sp || is_bs) begin
					nxt = hzgb_pkg::ST_ZW;
				end else if (gb_half) begin
					out_b = in_byte | hzgb_pkg::GB_MARK;
					nxt   = hzgb_pkg::ST_ZW;
				end
			end
			default: begin
				nxt = hzgb_pkg::ST_ASC;
			end
		endcase
	end

	assign res.out_byte        = out_b;
	assign res.next.state      = nxt;
	assign res.next.line_start = (out_b == hzgb_pkg::CH_LF) || (out_b == hzgb_pkg::CH_CR);

endmodule

// File: hdl/hzgb_state.sv
// Per-channel decoder state registers with one read and one write port.
module hzgb_state #(
	parameter int DEPTH = 8,
	parameter int IDX_W = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IDX_W-1:0]      rd_idx,
	output hzgb_pkg::chan_state_t rd_data,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_idx,
	input  hzgb_pkg::chan_state_t wr_data
);

	hzgb_pkg::chan_state_t st_q [DEPTH];

	// state update; reset puts every channel in ascii, not at line start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				st_q[i].state      <= hzgb_pkg::ST_ASC;
				st_q[i].line_start <= 1'b0;
			end
		end else if (wr_en) begin
			st_q[wr_idx] <= wr_data;
		end
	end

	assign rd_data = st_q[rd_idx];

endmodule

// File: hdl/hz_to_gb_byte_decoder_core.sv
// Top level of the HZ to GB byte decoder: handshake, stage registers and state store.
//
// Usage:
//   Input channel s_*: each transaction carries one byte of HZ text and the
//   number of the decoder channel it belongs to. Every channel decodes
//   independently. Output channel m_*: one transaction per input transaction,
//   in order, carrying the same byte with bit 7 set when it is a GB half
//   inside a "~{ ... ~}" span or on a "zW" line.
//   Bytes on a channel number of CHANNELS or more pass through unchanged.
//
// Pipeline: an accepted input byte passes the input stage register, then the
// output register, which drives m_tvalid. Throughput: one byte per cycle while
// m_tready is high; the channel state is read and written back in the stage
// that loads the output register, so consecutive bytes of the same channel
// follow without bubbles.
//
// Reset: arst_n clears both stages and puts every channel in ascii state
// with the line-start flag clear.
// Stall: while m_tready is low the output holds; one more byte can sit in
// the input stage, after which s_tready drops until the output drains.
module hz_to_gb_byte_decoder_core #(
	parameter int CHANNELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] in_byte, [10:8] channel, [15:11] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [7:0] out_byte
);

	// only channel numbers the 3-bit field can reach need storage
	localparam int REACH = 1 << hzgb_pkg::CHANNEL_W;
	localparam int DEPTH = (CHANNELS < REACH) ? CHANNELS : REACH;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                            valid_s1;
	logic [hzgb_pkg::BYTE_W-1:0]     byte_s1;
	logic [hzgb_pkg::CHANNEL_W-1:0]  chan_s1;
	logic                            advance;
	logic                            in_range;
	logic [IDX_W-1:0]                idx;
	hzgb_pkg::chan_state_t           cur_st;
	hzgb_pkg::decode_res_t           res;
	logic                            out_valid_q;
	logic [hzgb_pkg::BYTE_W-1:0]     out_byte_q;

	// stage 1 moves on when the output register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[7:0];
			chan_s1 <= s_tdata[10:8];
		end
	end

	// channel lookup
	assign in_range = (int'(chan_s1) < CHANNELS);
	assign idx      = in_range ? chan_s1[IDX_W-1:0] : '0;

	hzgb_state #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (idx),
		.rd_data (cur_st),
		.wr_en   (advance && in_range),
		.wr_idx  (idx),
		.wr_data (res.next)
	);

	hzgb_decode u_decode (
		.in_byte (byte_s1),
		.cur     (cur_st),
		.res     (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= in_range ? res.out_byte : byte_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;

	// checks
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("output register not loaded after stage advance");

	a_low_bits_kept: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (m_tdata[6:0] == $past(byte_s1[6:0])))
		else $error("decoder altered the low seven bits of a byte");

	a_out_of_range_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !in_range) |=> (m_tdata == $past(byte_s1)))
		else $error("byte on an unused channel was modified");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while the output register is empty");

endmodule

// File: test/hz_to_gb_byte_decoder_core_tb.sv
// Testbench for the HZ to GB byte decoder: directed and random text on all channels.
`timescale 1ns / 1ps

module hz_to_gb_byte_decoder_core_tb;

	localparam int CHANNELS       = 8;
	localparam int HOLDOFF_CYCLES = 150;
	localparam int CYCLE_LIMIT    = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;    // [7:0] in_byte, [10:8] channel, [15:11] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [7:0] out_byte

	// Predicted per-channel decoder state
	hzgb_pkg::decode_state_t chan_state [CHANNELS];
	logic                    chan_line_start [CHANNELS];

	logic [7:0] out_byte_q [$];
	int         err_count = 0;
	int         cycle_count = 0;

	// Idle controls shared by the test tasks
	int   gap_max = 0;
	int   burst_left = 0;
	bit   stall_on = 1'b0;
	bit   holdoff_req = 1'b0;
	logic [15:0] ready_pat = 16'hffff;
	int   pat_age = 0;

	hz_to_gb_byte_decoder_core #(
		.CHANNELS(CHANNELS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Low 7 bits in the printable GB range, bit 7 ignored
	function automatic bit is_gb_half(input logic [7:0] b);
		return (b[6:0] >= hzgb_pkg::GB_LOW) && (b[6:0] <= hzgb_pkg::GB_HIGH);
	endfunction

	// Decode one byte on one channel and advance that channel's state
	function automatic logic [7:0] decode_hz_byte(input logic [7:0] b, input logic [2:0] ch);
		hzgb_pkg::decode_state_t cur;
		hzgb_pkg::decode_state_t nxt;
		logic [7:0]              res;
		cur = chan_state[ch];
		nxt = hzgb_pkg::ST_ASC;
		res = b;
		if (int'(ch) >= CHANNELS)
			return b;
		case (cur)
			hzgb_pkg::ST_ASC: begin
				if (b == hzgb_pkg::CH_TILDE)
					nxt = hzgb_pkg::ST_PHZ;
				else if (b == hzgb_pkg::CH_Z && chan_line_start[ch])
					nxt = hzgb_pkg::ST_PZW;
			end
			hzgb_pkg::ST_PHZ:
				nxt = (b == hzgb_pkg::CH_LBRACE) ? hzgb_pkg::ST_HZ : hzgb_pkg::ST_ASC;
			hzgb_pkg::ST_HZ: begin
				if (b == hzgb_pkg::CH_TILDE) begin
					nxt = hzgb_pkg::ST_HZT;
				end else if (b == hzgb_pkg::CH_SPACE) begin
					nxt = hzgb_pkg::ST_HZA;
				end else if (b == hzgb_pkg::CH_BS) begin
					nxt = hzgb_pkg::ST_HZ2;
				end else if (is_gb_half(b)) begin
					res = b | hzgb_pkg::GB_MARK;
					nxt = hzgb_pkg::ST_HZ2;
				end
			end
			hzgb_pkg::ST_HZA: nxt = hzgb_pkg::ST_HZ;
			hzgb_pkg::ST_HZ2: begin
				if (b == hzgb_pkg::CH_SPACE || b == hzgb_pkg::CH_BS) begin
					nxt = hzgb_pkg::ST_HZ;
				end else if (is_gb_half(b)) begin
					res = b | hzgb_pkg::GB_MARK;
					nxt = hzgb_pkg::ST_HZ;
				end
			end
			hzgb_pkg::ST_HZT:
				nxt = (b == hzgb_pkg::CH_RBRACE) ? hzgb_pkg::ST_ASC : hzgb_pkg::ST_HZ;
			hzgb_pkg::ST_PZW:
				nxt = (b == hzgb_pkg::CH_W) ? hzgb_pkg::ST_ZW : hzgb_pkg::ST_ASC;
			hzgb_pkg::ST_ZW: begin
				if (b == hzgb_pkg::CH_SPACE) begin
					nxt = hzgb_pkg::ST_ZWA;
				end else if (b == hzgb_pkg::CH_LF || b == hzgb_pkg::CH_CR) begin
					nxt = hzgb_pkg::ST_ASC;
				end else if (is_gb_half(b)) begin
					res = b | hzgb_pkg::GB_MARK;
					nxt = hzgb_pkg::ST_ZW2;
				end
			end
			hzgb_pkg::ST_ZWA: nxt = hzgb_pkg::ST_ZW;
			hzgb_pkg::ST_ZW2: begin
				if (b == hzgb_pkg::CH_SPACE || b == hzgb_pkg::CH_BS) begin
					nxt = hzgb_pkg::ST_ZW;
				end else if (is_gb_half(b)) begin
					res = b | hzgb_pkg::GB_MARK;
					nxt = hzgb_pkg::ST_ZW;
				end
			end
			default: nxt = hzgb_pkg::ST_ASC;
		endcase
		chan_state[ch] = nxt;
		chan_line_start[ch] = (res == hzgb_pkg::CH_LF || res == hzgb_pkg::CH_CR);
		return res;
	endfunction

	// Pick a byte that mostly keeps the channel's text well formed
	function automatic logic [7:0] pick_text_byte(input logic [2:0] ch, input int noise_pct);
		logic [7:0] gb;
		int         r;
		gb = 8'($urandom_range(8'h7e, 8'h21));
		if ($urandom_range(1) == 1)
			gb[7] = 1'b1;
		r = $urandom_range(9);
		if ($urandom_range(99) < noise_pct)
			return 8'($urandom_range(255));
		case (chan_state[ch])
			hzgb_pkg::ST_ASC: begin
				if (r < 4)
					return hzgb_pkg::CH_TILDE;
				else if (r < 6)
					return chan_line_start[ch] ? hzgb_pkg::CH_Z : hzgb_pkg::CH_LF;
				else if (r == 6)
					return hzgb_pkg::CH_CR;
				else
					return 8'($urandom_range(8'h7e, 8'h20));
			end
			hzgb_pkg::ST_PHZ: return (r < 8) ? hzgb_pkg::CH_LBRACE : gb;
			hzgb_pkg::ST_PZW: return (r < 8) ? hzgb_pkg::CH_W : gb;
			hzgb_pkg::ST_HZT: return (r < 6) ? hzgb_pkg::CH_RBRACE : gb;
			hzgb_pkg::ST_HZ, hzgb_pkg::ST_HZ2, hzgb_pkg::ST_HZA: begin
				case (r)
					0: return hzgb_pkg::CH_TILDE;
					1: return hzgb_pkg::CH_SPACE;
					2: return hzgb_pkg::CH_BS;
					default: return gb;
				endcase
			end
			hzgb_pkg::ST_ZW, hzgb_pkg::ST_ZW2, hzgb_pkg::ST_ZWA: begin
				case (r)
					0: return ($urandom_range(1) == 1) ? hzgb_pkg::CH_LF : hzgb_pkg::CH_CR;
					1: return hzgb_pkg::CH_SPACE;
					2: return hzgb_pkg::CH_BS;
					default: return gb;
				endcase
			end
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Offer one byte, with a random gap between bursts; valid stays high afterward
	task automatic send_byte(input logic [7:0] b, input logic [2:0] ch);
		int gap;
		gap = 0;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(12, 1);
			if (gap_max > 0)
				gap = $urandom_range(gap_max);
		end
		burst_left--;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {5'b0, ch, b};
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		out_byte_q.push_back(decode_hz_byte(b, ch));
	endtask

	task automatic release_bus();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_text(input int count, input int noise_pct);
		logic [2:0] ch;
		for (int i = 0; i < count; i++) begin
			ch = 3'($urandom_range(CHANNELS - 1));
			send_byte(pick_text_byte(ch, noise_pct), ch);
		end
	endtask

	// Spans, pairing rules, zW lines and line-start handling
	task automatic test_directed();
		logic [7:0] hz_seq [14];
		logic [7:0] zw_seq [17];
		gap_max = 0;
		stall_on = 1'b0;
		hz_seq = '{hzgb_pkg::CH_TILDE, hzgb_pkg::CH_LBRACE, 8'h21, 8'h7e, 8'ha1, 8'ha2,
			hzgb_pkg::CH_SPACE, 8'h41, hzgb_pkg::CH_BS, hzgb_pkg::CH_SPACE,
			hzgb_pkg::CH_TILDE, 8'h41, hzgb_pkg::CH_TILDE, hzgb_pkg::CH_RBRACE};
		zw_seq = '{hzgb_pkg::CH_LF, hzgb_pkg::CH_Z, hzgb_pkg::CH_W, 8'h30, 8'h31,
			hzgb_pkg::CH_SPACE, 8'h32, 8'h33, hzgb_pkg::CH_BS, hzgb_pkg::CH_BS,
			hzgb_pkg::CH_CR, hzgb_pkg::CH_Z, hzgb_pkg::CH_W, hzgb_pkg::CH_LF,
			hzgb_pkg::CH_Z, 8'h78, hzgb_pkg::CH_Z};
		foreach (hz_seq[i])
			send_byte(hz_seq[i], 3'd0);
		send_byte(8'hff, 3'd0);
		foreach (zw_seq[i])
			send_byte(zw_seq[i], 3'd7);
		// 'z' on a fresh channel is not at line start
		send_byte(hzgb_pkg::CH_Z, 3'd3);
		send_byte(hzgb_pkg::CH_W, 3'd3);
		send_byte(8'h00, 3'd3);
		send_byte(8'h80, 3'd5);
		release_bus();
	endtask

	task automatic test_wellformed_text();
		gap_max = 8;
		stall_on = 1'b1;
		send_text(260, 10);
		release_bus();
	endtask

	task automatic test_noise();
		gap_max = 4;
		stall_on = 1'b1;
		send_text(120, 100);
		release_bus();
	endtask

	task automatic test_no_idle();
		gap_max = 0;
		stall_on = 1'b0;
		send_text(80, 15);
		release_bus();
	endtask

	// Output held off while input keeps coming, so the input stage stalls
	task automatic test_backpressure();
		gap_max = 0;
		stall_on = 1'b1;
		holdoff_req = 1'b1;
		send_text(60, 10);
		release_bus();
	endtask

	// m_tready: long hold-off on request, else rotating random pattern or always high
	always @(negedge clk) begin
		if (holdoff_req) begin
			m_tready = 1'b0;
			repeat (HOLDOFF_CYCLES) @(negedge clk);
			holdoff_req = 1'b0;
		end else if (stall_on) begin
			m_tready = ready_pat[0];
			ready_pat = {ready_pat[0], ready_pat[15:1]};
			pat_age++;
			if (pat_age >= 40) begin
				pat_age = 0;
				ready_pat = 16'($urandom);
			end
		end else begin
			m_tready = 1'b1;
		end
	end

	// Compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (out_byte_q.size() == 0) begin
				$error("out_byte with nothing expected: actual %02h", m_tdata);
				err_count++;
			end else if (m_tdata !== out_byte_q[0]) begin
				$error("out_byte mismatch: expected %02h, actual %02h", out_byte_q[0], m_tdata);
				err_count++;
				void'(out_byte_q.pop_front());
			end else begin
				void'(out_byte_q.pop_front());
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("hz_to_gb_byte_decoder_core_tb failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < CHANNELS; i++) begin
			chan_state[i] = hzgb_pkg::ST_ASC;
			chan_line_start[i] = 1'b0;
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_wellformed_text();
		test_noise();
		test_no_idle();
		test_backpressure();

		// Drain, then allow for the pipeline latency
		while (out_byte_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("hz_to_gb_byte_decoder_core_tb passed");
		else
			$display("hz_to_gb_byte_decoder_core_tb failed");
		$finish;
	end

endmodule
